// File: hdl/bfgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_pkg
// shared types and codes of the bitmap font glyph renderer
// ----------------------------------------------------------------------------
package bfgr_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_DRAW    = 2'd1;
  localparam logic [1:0] CMD_MEASURE = 2'd2;

  localparam logic [1:0] KIND_FILL   = 2'd0;
  localparam logic [1:0] KIND_ROW    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;
  localparam logic [1:0] KIND_MEAS   = 2'd3;

  localparam logic CFG_FONT_LENGTH = 1'b0;
  localparam logic CFG_STUB_CODE   = 1'b1;

  localparam int ADDR_W = 17;  // wide enough for any walk cursor
  localparam logic [7:0] SPACE_CODE = 8'd32;
  localparam logic [ADDR_W-1:0] HDR_BYTES   = 17'd5;
  localparam logic [ADDR_W-1:0] REC_HDR     = 17'd7;
  localparam logic [ADDR_W-1:0] SIZE_ADDR   = 17'd2;
  localparam logic [ADDR_W-1:0] SPACE_ADDR  = 17'd4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [11:0] load_address;
    logic [7:0]  load_byte;
    logic [7:0]  char_code;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic        inverse;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [8:0]  top;
    logic [8:0]  left;
    logic [8:0]  bottom;
    logic [8:0]  right;
    logic [31:0] row_bits;
    logic [5:0]  row_width;
    logic        ok;
    logic [8:0]  next_x;
    logic [7:0]  advance;
    logic        last;
  } out_t;

  typedef struct packed {
    logic                we;
    logic [11:0]         waddr;
    logic [7:0]          wdata;
    logic                rd_en;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage
`default_nettype wire

// File: hdl/bfgr_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_mem
// font byte memory, one write and one registered read port
// ----------------------------------------------------------------------------
module bfgr_mem
  import bfgr_pkg::*;
#(
  parameter int FONT_BYTES = 4096
) (
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output logic [7:0]    rdata_o
);
  localparam int AW = $clog2(FONT_BYTES);

  logic [7:0]        mem [FONT_BYTES];
  logic [7:0]        rdata_q;
  logic              oob_q;
  logic [ADDR_W-1:0] waddr_ext;

  assign waddr_ext = {{(ADDR_W-12){1'b0}}, req_i.waddr};

  always_ff @(posedge clk_i) begin
    if (req_i.we && (waddr_ext < ADDR_W'(FONT_BYTES))) begin
      mem[waddr_ext[AW-1:0]] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.raddr[AW-1:0]];
      oob_q   <= (req_i.raddr >= ADDR_W'(FONT_BYTES));
    end
  end

  // reads beyond the memory give zero
  assign rdata_o = oob_q ? 8'd0 : rdata_q;

endmodule
`default_nettype wire

// File: hdl/bfgr_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_seq
// command sequencer: glyph walk, field fetch and bit-serial row build
// ----------------------------------------------------------------------------
module bfgr_seq
  import bfgr_pkg::*;
#(
  parameter int FONT_BYTES       = 4096,
  parameter int SCREEN_WIDTH     = 128,
  parameter int SCREEN_HEIGHT    = 64,
  parameter int MAX_GLYPH_WIDTH  = 32,
  parameter int MAX_GLYPH_HEIGHT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [12:0] cfg_data_i,
  output mem_req_t         mem_o,
  input  wire logic [7:0]  mem_rdata_i
);
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOOK  = 5'd1;
  localparam logic [4:0] S_CODE  = 5'd2;
  localparam logic [4:0] S_WID   = 5'd3;
  localparam logic [4:0] S_HGT   = 5'd4;
  localparam logic [4:0] S_STEP  = 5'd5;
  localparam logic [4:0] S_FLD   = 5'd6;
  localparam logic [4:0] S_FLDW  = 5'd7;
  localparam logic [4:0] S_CHECK = 5'd8;
  localparam logic [4:0] S_TOPF  = 5'd9;
  localparam logic [4:0] S_BOTF  = 5'd10;
  localparam logic [4:0] S_ROW   = 5'd11;
  localparam logic [4:0] S_FETCH = 5'd12;
  localparam logic [4:0] S_BITS  = 5'd13;
  localparam logic [4:0] S_EROW  = 5'd14;
  localparam logic [4:0] S_RGTF  = 5'd15;
  localparam logic [4:0] S_STAT  = 5'd16;
  localparam logic [4:0] S_MEAS  = 5'd17;
  localparam logic [4:0] S_SPACE = 5'd18;
  localparam logic [4:0] S_SPW   = 5'd19;

  logic [4:0]        state_q, state_d;
  logic [12:0]       font_len_q;
  logic [7:0]        stub_q;
  logic              draw_q, inv_q, ok_q;
  logic [7:0]        code_q, px_q, py_q;
  logic [ADDR_W-1:0] cur_q, fb_q, g_q, lim;
  logic [7:0]        w_q, h_q, xo_q, yo_q, adv_q, fs_q;
  logic [15:0]       prod_q;
  logic [2:0]        fcnt_q;
  logic [7:0]        i_q;
  logic [6:0]        j_q;
  logic [11:0]       bidx_q;
  logic [31:0]       bits_q;
  logic              out_valid_q;
  out_t              out_q, item;
  logic              slot_free, emit, accept, fail, bot_ok, rgt_ok, bit_v;
  logic [ADDR_W-1:0] step_len;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lim = ({4'd0, font_len_q} > ADDR_W'(FONT_BYTES)) ? ADDR_W'(FONT_BYTES)
                                                          : {4'd0, font_len_q};
  assign step_len = REC_HDR + ADDR_W'((17'(prod_q) + 17'd7) >> 3);

  assign fail = ({2'd0, px_q} >= 10'(SCREEN_WIDTH)) || ({2'd0, py_q} >= 10'(SCREEN_HEIGHT)) ||
                ({2'd0, px_q} + {2'd0, w_q} > 10'(SCREEN_WIDTH)) ||
                ({2'd0, py_q} + {2'd0, fs_q} > 10'(SCREEN_HEIGHT)) ||
                ({2'd0, w_q} > 10'(MAX_GLYPH_WIDTH)) || ({2'd0, h_q} > 10'(MAX_GLYPH_HEIGHT));
  assign bot_ok = ({2'd0, h_q} + {2'd0, yo_q} + 10'd1) <= {2'd0, fs_q};
  assign rgt_ok = ({2'd0, xo_q} + {2'd0, w_q} + 10'd1) <= {2'd0, adv_q} && (fs_q != 8'd0);
  assign bit_v  = mem_rdata_i[3'd7 - bidx_q[2:0]] ^ inv_q;

  // memory requests
  always_comb begin
    mem_o       = '0;
    mem_o.we    = accept && (in_data_i.cmd == CMD_LOAD);
    mem_o.waddr = in_data_i.load_address;
    mem_o.wdata = in_data_i.load_byte;
    unique case (state_q)
      S_LOOK: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = cur_q;
      end
      S_CODE: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = cur_q + ADDR_W'(1);
      end
      S_WID: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = cur_q + ADDR_W'(2);
      end
      S_FLD: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = (fcnt_q == 3'd5) ? SIZE_ADDR : g_q + ADDR_W'(fcnt_q) + ADDR_W'(1);
      end
      S_SPACE: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = SPACE_ADDR;
      end
      S_FETCH: begin
        mem_o.rd_en = 1'b1;
        mem_o.raddr = g_q + REC_HDR + ADDR_W'(bidx_q >> 3);
      end
      default: ;
    endcase
  end

  // result item for the current emit state
  always_comb begin
    item = '0;
    unique case (state_q)
      S_TOPF: begin
        item.kind   = KIND_FILL;
        item.top    = {1'b0, py_q};
        item.left   = {1'b0, px_q};
        item.bottom = {1'b0, py_q} + {1'b0, yo_q} - 9'd1;
        item.right  = {1'b0, px_q} + {1'b0, w_q} - 9'd1;
      end
      S_BOTF: begin
        item.kind   = KIND_FILL;
        item.top    = {1'b0, py_q} + {1'b0, h_q} + {1'b0, yo_q};
        item.left   = {1'b0, px_q};
        item.bottom = {1'b0, py_q} + {1'b0, fs_q} - 9'd1;
        item.right  = {1'b0, px_q} + {1'b0, w_q} - 9'd1;
      end
      S_EROW: begin
        item.kind      = KIND_ROW;
        item.top       = {1'b0, py_q} + {1'b0, yo_q} + {1'b0, i_q};
        item.left      = {1'b0, px_q} + {1'b0, xo_q};
        item.row_bits  = bits_q;
        item.row_width = w_q[5:0];
      end
      S_RGTF: begin
        item.kind   = KIND_FILL;
        item.top    = {1'b0, py_q};
        item.left   = {1'b0, px_q} + {1'b0, xo_q} + {1'b0, w_q};
        item.bottom = {1'b0, py_q} + {1'b0, fs_q} - 9'd1;
        item.right  = {1'b0, px_q} + {1'b0, adv_q} - 9'd1;
      end
      S_STAT: begin
        item.kind   = KIND_STATUS;
        item.ok     = ok_q;
        item.next_x = ok_q ? {1'b0, px_q} + {1'b0, adv_q} : {1'b0, px_q};
        item.last   = 1'b1;
      end
      S_MEAS: begin
        item.kind    = KIND_MEAS;
        item.advance = adv_q;
        item.last    = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CMD_DRAW) begin
            state_d = S_LOOK;
          end else if (in_data_i.cmd == CMD_MEASURE) begin
            state_d = (in_data_i.char_code == SPACE_CODE) ? S_SPACE : S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (cur_q >= lim) begin
          if (fb_q == '0) state_d = draw_q ? S_STAT : S_MEAS;
          else state_d = S_FLD;
        end else begin
          state_d = S_CODE;
        end
      end
      S_CODE: state_d = (mem_rdata_i == code_q) ? S_FLD : S_WID;
      S_WID:  state_d = S_HGT;
      S_HGT:  state_d = S_STEP;
      S_STEP: state_d = S_LOOK;
      S_FLD:  state_d = S_FLDW;
      S_FLDW: begin
        if (!draw_q) state_d = S_MEAS;
        else if (fcnt_q == 3'd5) state_d = S_CHECK;
        else state_d = S_FLD;
      end
      S_CHECK: begin
        if (fail) state_d = S_STAT;
        else if (inv_q && (w_q != 8'd0)) state_d = S_TOPF;
        else state_d = S_ROW;
      end
      S_TOPF: begin
        if (yo_q == 8'd0) state_d = S_BOTF;
        else if (slot_free) begin
          emit = 1'b1;
          state_d = S_BOTF;
        end
      end
      S_BOTF: begin
        if (!bot_ok) state_d = S_ROW;
        else if (slot_free) begin
          emit = 1'b1;
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        if (i_q == h_q) state_d = S_RGTF;
        else if (w_q == 8'd0) state_d = S_EROW;
        else state_d = S_FETCH;
      end
      S_FETCH: state_d = S_BITS;
      S_BITS: begin
        if (j_q + 7'd1 == w_q[6:0]) state_d = S_EROW;
        else if (bidx_q[2:0] == 3'd7) state_d = S_FETCH;
      end
      S_EROW: begin
        if (slot_free) begin
          emit = 1'b1;
          state_d = S_ROW;
        end
      end
      S_RGTF: begin
        if (!(inv_q && rgt_ok)) state_d = S_STAT;
        else if (slot_free) begin
          emit = 1'b1;
          state_d = S_STAT;
        end
      end
      S_STAT, S_MEAS: begin
        if (slot_free) begin
          emit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SPACE: state_d = S_SPW;
      S_SPW:   state_d = S_MEAS;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      font_len_q  <= '0;
      stub_q      <= '0;
    end else begin
      state_q <= state_d;
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_FONT_LENGTH) font_len_q <= cfg_data_i;
        else stub_q <= cfg_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_q <= item;
    unique case (state_q)
      S_IDLE: begin
        draw_q <= (in_data_i.cmd == CMD_DRAW);
        code_q <= in_data_i.char_code;
        px_q   <= in_data_i.pos_x;
        py_q   <= in_data_i.pos_y;
        inv_q  <= in_data_i.inverse;
        cur_q  <= HDR_BYTES;
        fb_q   <= '0;
        adv_q  <= '0;
        ok_q   <= 1'b0;
        fcnt_q <= (in_data_i.cmd == CMD_DRAW) ? 3'd0 : 3'd4;
      end
      S_LOOK: g_q <= fb_q;
      S_CODE: begin
        if (mem_rdata_i == code_q) g_q <= cur_q;
        else if (mem_rdata_i == stub_q) fb_q <= cur_q;
      end
      S_WID:  w_q <= mem_rdata_i;
      S_HGT:  prod_q <= w_q * mem_rdata_i;
      S_STEP: cur_q <= cur_q + step_len;
      S_FLDW: begin
        case (fcnt_q)
          3'd0:    w_q  <= mem_rdata_i;
          3'd1:    h_q  <= mem_rdata_i;
          3'd2:    xo_q <= mem_rdata_i;
          3'd3:    yo_q <= mem_rdata_i;
          3'd4:    adv_q <= mem_rdata_i;
          default: fs_q <= mem_rdata_i;
        endcase
        fcnt_q <= fcnt_q + 3'd1;
      end
      S_CHECK: begin
        ok_q   <= !fail;
        i_q    <= '0;
        bidx_q <= '0;
      end
      S_ROW: begin
        j_q    <= '0;
        bits_q <= '0;
      end
      S_BITS: begin
        if (j_q < 7'd32) bits_q[j_q[4:0]] <= bit_v;
        j_q    <= j_q + 7'd1;
        bidx_q <= bidx_q + 12'd1;
      end
      S_EROW: if (slot_free) i_q <= i_q + 8'd1;
      S_SPW:  adv_q <= mem_rdata_i;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/bitmap_font_glyph_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_font_glyph_renderer_top
// bitmap font store with glyph draw and measure commands
// ----------------------------------------------------------------------------
// A draw or measure walks the glyph records through the single font
// memory read port, then fetches the glyph fields: six reads for a draw,
// the advance alone for a measure; a measure of the space code skips the
// walk and reads only the space advance. Pixel rows are built one bit per
// cycle, with a fetch for each font byte, and every result beat waits
// for a free output register. The input is stalled until the last
// result beat is loaded.
module bitmap_font_glyph_renderer_top
  import bfgr_pkg::*;
#(
  parameter int FONT_BYTES       = 4096,
  parameter int SCREEN_WIDTH     = 128,
  parameter int SCREEN_HEIGHT    = 64,
  parameter int MAX_GLYPH_WIDTH  = 32,
  parameter int MAX_GLYPH_HEIGHT = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_t         in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_t             out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [12:0] cfg_data_i
);
  mem_req_t   mem_req;
  logic [7:0] mem_rdata;

  bfgr_mem #(.FONT_BYTES(FONT_BYTES)) u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  bfgr_seq #(
    .FONT_BYTES       (FONT_BYTES),
    .SCREEN_WIDTH     (SCREEN_WIDTH),
    .SCREEN_HEIGHT    (SCREEN_HEIGHT),
    .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
    .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata)
  );

endmodule
`default_nettype wire

// File: hdl/bfgr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfgr_checker
// port-level checks of the glyph renderer
// ----------------------------------------------------------------------------
module bfgr_checker
  import bfgr_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire in_t         in_data_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire out_t        out_data_o,
  input wire logic        cfg_we_i,
  input wire logic        cfg_index_i,
  input wire logic [12:0] cfg_data_i
);
  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // a load produces nothing and leaves the input open
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.cmd == CMD_LOAD) |=> !in_stall_o)
    else $error("load kept the input stalled");

  // closing beats are status or measure answers
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.kind == KIND_STATUS) || (out_data_o.kind == KIND_MEAS))
    |-> out_data_o.last)
    else $error("status beat without last");

  a_mid_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_data_o.kind == KIND_FILL) || (out_data_o.kind == KIND_ROW))
    |-> !out_data_o.last)
    else $error("fill or row beat marked last");

  // stalled input beat holds until taken
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat changed");

endmodule

bind bitmap_font_glyph_renderer_top bfgr_checker u_bfgr_checker (.*);
`default_nettype wire
